### hdl/rrt_pkg.sv
// shared types, codes and constants of the request retransmit tracker
// no dependencies; imported by every module of the block
package rrt_pkg;

  localparam int TW = 48;
  localparam int SW = 16;
  localparam int RW = 8;
  localparam int ALU_W = 56;
  localparam int DEF_TABLE_DEPTH = 16;

  localparam logic [TW-1:0] RTO_INIT = 48'd1000000000;
  localparam logic [15:0] MAX_REQ_RST = 16'd100;
  localparam logic [7:0] MAX_RETRY_RST = 8'd5;
  localparam logic [2:0] ALPHA_RST = 3'd3;
  localparam logic [2:0] BETA_RST = 3'd2;
  localparam logic [2:0] VAR_MULT_RST = 3'd2;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_REPLY = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_SENT = 3'd0,
    ST_RETX = 3'd1,
    ST_GAVE_UP = 3'd2,
    ST_REPLY_OK = 3'd3,
    ST_UNEXPECTED = 3'd4,
    ST_COUNT_DONE = 3'd5,
    ST_TABLE_FULL = 3'd6,
    ST_UNKNOWN_TO = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    CFG_MAX_REQUESTS = 3'd0,
    CFG_MAX_RETRIES = 3'd1,
    CFG_ALPHA_SHIFT = 3'd2,
    CFG_BETA_SHIFT = 3'd3,
    CFG_VAR_MULT_SHIFT = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_RIGHT = 2'd1,
    SH_LEFT = 2'd2
  } shdir_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [SW-1:0] serial_number;
    logic [TW-1:0] now_ns;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [SW-1:0] result_serial;
    logic [TW-1:0] timeout_ns;
    logic [TW-1:0] rtt_ns;
  } out_item_t;

  typedef struct packed {
    logic [SW-1:0] serial;
    logic [TW-1:0] send_time;
    logic [RW-1:0] retries;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic vld_we;
    logic vld_val;
  } tbl_ctl_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic sub;
    shdir_e dir;
    logic [2:0] amt;
  } alu_req_t;

endpackage

### hdl/rrt_table.sv
// request table: entry memory with registered read and per-entry valid flops
// depends on rrt_pkg
module rrt_table import rrt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int IdxW = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tbl_ctl_t               ctl_i,
  input  logic [IdxW-1:0]        rd_addr_i,
  input  logic [IdxW-1:0]        wr_addr_i,
  input  entry_t                 wr_data_i,
  output entry_t                 rd_data_o,
  output logic [TABLE_DEPTH-1:0] valid_o
);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;
  logic [TABLE_DEPTH-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en && (int'(rd_addr_i) < TABLE_DEPTH)) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.vld_we) begin
      vld_q[wr_addr_i] <= ctl_i.vld_val;
    end
  end

  assign rd_data_o = rd_q;
  assign valid_o = vld_q;

endmodule

### hdl/rrt_alu.sv
// shared add/subtract unit with operand shifter and registered result
// depends on rrt_pkg
module rrt_alu import rrt_pkg::*; (
  input  logic           clk_i,
  input  alu_req_t       req_i,
  output logic [ALU_W:0] res_o
);

  logic [ALU_W-1:0] b_sh;
  logic [ALU_W:0] res_d;
  logic [ALU_W:0] res_q;

  always_comb begin
    case (req_i.dir)
      SH_NONE: b_sh = req_i.b;
      SH_RIGHT: b_sh = req_i.b >> req_i.amt;
      SH_LEFT: b_sh = req_i.b << req_i.amt;
      default: b_sh = req_i.b;
    endcase
  end

  // msb is borrow on subtract, carry on add
  assign res_d = req_i.sub ? ({1'b0, req_i.a} - {1'b0, b_sh})
                           : ({1'b0, req_i.a} + {1'b0, b_sh});

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

### hdl/request_retransmit_tracker_rto_top.sv
// top level of the request retransmit tracker: sequencer, estimator registers
// and configuration; depends on rrt_pkg, rrt_table and rrt_alu
//
// usage:
//   input channel in_valid_i / in_stall_o / in_item_i carries one event item:
//   send, timeout or reply. output channel out_valid_o / out_stall_i /
//   out_item_o returns one result item per event; operation code 3 is
//   consumed without a result. configuration is a plain write port
//   (cfg_we_i, cfg_index_i, cfg_wdata_i), written while the block is idle;
//   the user must see to this, the block does not enforce it. one item at a
//   time: a send that hits the request limit goes straight to the output
//   state; other items scan the table one entry per cycle, and a reply that
//   finds its entry adds 2 to 8 adder steps; the next item is taken the cycle
//   after the result is loaded. the table read port and the shared adder set
//   this pacing.
//   reset clears the valid bits, the serial counter and the estimator, and
//   loads the timeout with one second. a stalled result holds in the output
//   register; the next item is still accepted and runs until its own result
//   needs that register.
module request_retransmit_tracker_rto_top import rrt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int IdxW = $clog2(TABLE_DEPTH);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SCAN  = 13'b0000000000010,
    S_RTT   = 13'b0000000000100,
    S_DIFF  = 13'b0000000001000,
    S_DABS  = 13'b0000000010000,
    S_VAR   = 13'b0000000100000,
    S_SRTT1 = 13'b0000001000000,
    S_SRTT2 = 13'b0000010000000,
    S_SRTT3 = 13'b0000100000000,
    S_SUM   = 13'b0001000000000,
    S_FIN   = 13'b0010000000000,
    S_MAXR  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  function automatic logic [ALU_W-1:0] ext(input logic [TW-1:0] x);
    return {{(ALU_W-TW){1'b0}}, x};
  endfunction

  state_e state_q, state_d;

  logic [15:0] max_req_q;
  logic [7:0] max_retry_q;
  logic [2:0] alpha_q, beta_q, vm_q;

  logic [SW-1:0] next_serial_q, next_serial_d;
  logic [TW-1:0] srtt_q, srtt_d;
  logic [TW-1:0] var_q, var_d;
  logic [TW-1:0] rto_q, rto_d;

  logic [1:0] op_q, op_d;
  logic [SW-1:0] ser_q, ser_d;
  logic [TW-1:0] now_q, now_d;
  status_e status_q, status_d;
  logic [SW-1:0] rser_q, rser_d;
  logic [TW-1:0] rtt_q, rtt_d;
  logic [TW-1:0] dif_q, dif_d;
  logic retr_nz_q, retr_nz_d;

  logic [IdxW-1:0] scan_cnt_q, scan_cnt_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic cmp_vld_q, cmp_vld_d;

  logic out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  tbl_ctl_t tbl_ctl;
  logic [IdxW-1:0] tbl_wr_addr;
  entry_t tbl_wr_data;
  entry_t tbl_rd_data;
  logic [TABLE_DEPTH-1:0] tbl_vld;

  alu_req_t alu_req;
  logic [ALU_W:0] alu_res;
  logic [TW-1:0] res48;
  logic borrow;
  logic [TW-1:0] sat_val;

  logic in_acc, out_load, cur_vld, hit, last;

  rrt_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (tbl_ctl),
    .rd_addr_i(scan_cnt_q),
    .wr_addr_i(tbl_wr_addr),
    .wr_data_i(tbl_wr_data),
    .rd_data_o(tbl_rd_data),
    .valid_o  (tbl_vld)
  );

  rrt_alu u_alu (
    .clk_i(clk_i),
    .req_i(alu_req),
    .res_o(alu_res)
  );

  assign res48 = alu_res[TW-1:0];
  assign borrow = alu_res[ALU_W];
  assign sat_val = (|alu_res[ALU_W:TW]) ? {TW{1'b1}} : alu_res[TW-1:0];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i && (state_q == S_IDLE);
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  assign cur_vld = tbl_vld[cmp_idx_q];
  assign hit = cmp_vld_q && ((op_q == OP_SEND) ? !cur_vld
                                               : (cur_vld && (tbl_rd_data.serial == ser_q)));
  assign last = (cmp_idx_q == IdxW'(TABLE_DEPTH - 1));

  always_comb begin
    state_d = state_q;
    next_serial_d = next_serial_q;
    srtt_d = srtt_q;
    var_d = var_q;
    rto_d = rto_q;
    op_d = op_q;
    ser_d = ser_q;
    now_d = now_q;
    status_d = status_q;
    rser_d = rser_q;
    rtt_d = rtt_q;
    dif_d = dif_q;
    retr_nz_d = retr_nz_q;
    scan_cnt_d = scan_cnt_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = cmp_vld_q;
    tbl_ctl = '0;
    tbl_wr_addr = cmp_idx_q;
    tbl_wr_data = tbl_rd_data;
    alu_req = '0;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        scan_cnt_d = '0;
        cmp_vld_d = 1'b0;
        if (in_acc) begin
          op_d = in_item_i.operation;
          ser_d = in_item_i.serial_number;
          now_d = in_item_i.now_ns;
          rser_d = in_item_i.serial_number;
          case (in_item_i.operation)
            OP_SEND: begin
              rser_d = next_serial_q;
              if (next_serial_q >= max_req_q) begin
                status_d = ST_COUNT_DONE;
                state_d = S_OUT;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_TIMEOUT, OP_REPLY: state_d = S_SCAN;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        tbl_ctl.rd_en = 1'b1;
        scan_cnt_d = scan_cnt_q + 1'b1;
        cmp_idx_d = scan_cnt_q;
        cmp_vld_d = 1'b1;
        if (hit) begin
          case (op_q)
            OP_SEND: begin
              tbl_ctl.wr_en = 1'b1;
              tbl_ctl.vld_we = 1'b1;
              tbl_ctl.vld_val = 1'b1;
              tbl_wr_data.serial = next_serial_q;
              tbl_wr_data.send_time = now_q;
              tbl_wr_data.retries = '0;
              next_serial_d = next_serial_q + 1'b1;
              status_d = ST_SENT;
              state_d = S_OUT;
            end
            OP_TIMEOUT: begin
              if (tbl_rd_data.retries < max_retry_q) begin
                tbl_ctl.wr_en = 1'b1;
                tbl_wr_data.send_time = now_q;
                tbl_wr_data.retries = tbl_rd_data.retries + 1'b1;
                status_d = ST_RETX;
              end else begin
                tbl_ctl.vld_we = 1'b1;
                tbl_ctl.vld_val = 1'b0;
                status_d = ST_GAVE_UP;
              end
              state_d = S_OUT;
            end
            default: begin
              tbl_ctl.vld_we = 1'b1;
              tbl_ctl.vld_val = 1'b0;
              retr_nz_d = (tbl_rd_data.retries != '0);
              alu_req.a = ext(now_q);
              alu_req.b = ext(tbl_rd_data.send_time);
              alu_req.sub = 1'b1;
              status_d = ST_REPLY_OK;
              state_d = S_RTT;
            end
          endcase
        end else if (cmp_vld_q && last) begin
          case (op_q)
            OP_SEND: status_d = ST_TABLE_FULL;
            OP_TIMEOUT: status_d = ST_UNKNOWN_TO;
            default: status_d = ST_UNEXPECTED;
          endcase
          state_d = S_OUT;
        end
      end
      S_RTT: begin
        rtt_d = res48;
        if (retr_nz_q) begin
          alu_req.a = ext(rto_q);
          alu_req.b = ext(res48);
          alu_req.sub = 1'b1;
          state_d = S_MAXR;
        end else if (srtt_q == '0) begin
          var_d = res48 >> 1;
          srtt_d = res48;
          state_d = S_SUM;
        end else begin
          alu_req.a = ext(srtt_q);
          alu_req.b = ext(res48);
          alu_req.sub = 1'b1;
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        if (borrow) begin
          alu_req.a = ext(rtt_q);
          alu_req.b = ext(srtt_q);
          alu_req.sub = 1'b1;
          state_d = S_DABS;
        end else begin
          dif_d = res48;
          alu_req.a = ext(var_q);
          alu_req.b = ext(var_q);
          alu_req.sub = 1'b1;
          alu_req.dir = SH_RIGHT;
          alu_req.amt = beta_q;
          state_d = S_VAR;
        end
      end
      S_DABS: begin
        dif_d = res48;
        alu_req.a = ext(var_q);
        alu_req.b = ext(var_q);
        alu_req.sub = 1'b1;
        alu_req.dir = SH_RIGHT;
        alu_req.amt = beta_q;
        state_d = S_VAR;
      end
      S_VAR: begin
        alu_req.a = ext(res48);
        alu_req.b = ext(dif_q);
        alu_req.dir = SH_RIGHT;
        alu_req.amt = beta_q;
        state_d = S_SRTT1;
      end
      S_SRTT1: begin
        var_d = res48;
        alu_req.a = ext(srtt_q);
        alu_req.b = ext(srtt_q);
        alu_req.sub = 1'b1;
        alu_req.dir = SH_RIGHT;
        alu_req.amt = alpha_q;
        state_d = S_SRTT2;
      end
      S_SRTT2: begin
        alu_req.a = ext(res48);
        alu_req.b = ext(rtt_q);
        alu_req.dir = SH_RIGHT;
        alu_req.amt = alpha_q;
        state_d = S_SRTT3;
      end
      S_SRTT3: begin
        srtt_d = res48;
        alu_req.a = ext(res48);
        alu_req.b = ext(var_q);
        alu_req.dir = SH_LEFT;
        alu_req.amt = vm_q;
        state_d = S_FIN;
      end
      S_SUM: begin
        alu_req.a = ext(srtt_q);
        alu_req.b = ext(var_q);
        alu_req.dir = SH_LEFT;
        alu_req.amt = vm_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        rto_d = sat_val;
        state_d = S_OUT;
      end
      S_MAXR: begin
        if (borrow) begin
          rto_d = rtt_q;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_d.status = status_q;
          out_d.result_serial = rser_q;
          out_d.timeout_ns = rto_q;
          out_d.rtt_ns = (status_q == ST_REPLY_OK) ? rtt_q : '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      next_serial_q <= '0;
      srtt_q <= '0;
      var_q <= '0;
      rto_q <= RTO_INIT;
      cmp_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      next_serial_q <= next_serial_d;
      srtt_q <= srtt_d;
      var_q <= var_d;
      rto_q <= rto_d;
      cmp_vld_q <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    ser_q <= ser_d;
    now_q <= now_d;
    status_q <= status_d;
    rser_q <= rser_d;
    rtt_q <= rtt_d;
    dif_q <= dif_d;
    retr_nz_q <= retr_nz_d;
    scan_cnt_q <= scan_cnt_d;
    cmp_idx_q <= cmp_idx_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_req_q <= MAX_REQ_RST;
      max_retry_q <= MAX_RETRY_RST;
      alpha_q <= ALPHA_RST;
      beta_q <= BETA_RST;
      vm_q <= VAR_MULT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_REQUESTS: max_req_q <= cfg_wdata_i;
        CFG_MAX_RETRIES: max_retry_q <= cfg_wdata_i[7:0];
        CFG_ALPHA_SHIFT: alpha_q <= cfg_wdata_i[2:0];
        CFG_BETA_SHIFT: beta_q <= cfg_wdata_i[2:0];
        CFG_VAR_MULT_SHIFT: vm_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

  // at most one entry is claimed per cycle
  a_one_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(tbl_vld) <= $countones($past(tbl_vld)) + 1))
    else $error("more than one table entry claimed in a cycle");

  // serial counter only advances after a send found a free entry
  a_serial_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_serial_q != $past(next_serial_q)) |->
      $past((state_q == S_SCAN) && (op_q == OP_SEND) && hit))
    else $error("serial counter advanced without a send");

  // an undefined operation is dropped without leaving idle
  a_drop_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_item_i.operation == OP_NONE)) |=>
      (state_q == S_IDLE))
    else $error("undefined operation started work");

endmodule
